### hw/rtl/htid_pkg.sv
// shared types, codes and helpers for the hilbert tile id converter
`default_nettype none

package htid_pkg;

  // operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // default highest zoom level
  localparam int ZOOM_LIMIT_DEF = 31;

  typedef struct packed {
    logic        operation;
    logic [4:0]  zoom;
    logic [30:0] x_coord;
    logic [30:0] y_coord;
    logic [63:0] tile_id;
  } req_t;

  typedef struct packed {
    logic [62:0] result_id;
    logic [4:0]  result_zoom;
    logic [30:0] result_x;
    logic [30:0] result_y;
    logic        out_of_range;
  } rsp_t;

  // count of tiles at all zooms below z: (4^z - 1) / 3, a 0101.. pattern
  function automatic logic [63:0] tiles_below(input logic [5:0] z);
    logic [63:0] r;
    r = '0;
    for (int t = 0; t < 32; t++) begin
      r[2*t] = (6'(t) < z);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/htid_level.sv
// one hilbert curve level, shared by encode and decode walks
`default_nettype none

module htid_level (
  input  wire logic        dir,
  input  wire logic [4:0]  lvl,
  input  wire logic [30:0] x_in,
  input  wire logic [30:0] y_in,
  input  wire logic [1:0]  quad_in,
  output logic [30:0]      x_out,
  output logic [30:0]      y_out,
  output logic [1:0]       quad_out
);
  import htid_pkg::*;

  logic [30:0] mask;
  logic [30:0] bit_s;
  logic        rx;
  logic        ry;
  logic [30:0] xm;
  logic [30:0] ym;
  logic [30:0] xr;
  logic [30:0] yr;

  assign bit_s = 31'(1) << lvl;
  assign mask  = bit_s - 31'(1);

  // quadrant bits for this level
  always_comb begin
    if (dir == OP_ENCODE) begin
      rx = x_in[lvl];
      ry = y_in[lvl];
    end else begin
      rx = quad_in[1];
      ry = quad_in[0] ^ quad_in[1];
    end
  end

  // encode emits the quadrant code (3*rx)^ry
  assign quad_out = {rx, rx ^ ry};

  // rotate / reflect the sub-square
  always_comb begin
    xm = x_in & mask;
    ym = y_in & mask;
    if (!ry) begin
      if (rx) begin
        xm = ~xm & mask;
        ym = ~ym & mask;
      end
      xr = ym;
      yr = xm;
    end else begin
      xr = xm;
      yr = ym;
    end
  end

  // decode places the quadrant bits at this level
  always_comb begin
    if (dir == OP_ENCODE) begin
      x_out = xr;
      y_out = yr;
    end else begin
      x_out = xr | (rx ? bit_s : '0);
      y_out = yr | (ry ? bit_s : '0);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hilbert_tile_id_convert.sv
// top level: tile coordinates <-> hilbert tile id converter
//
//   channel   handshake                      payload
//   request   start && !busy at rising edge  htid_pkg::req_t: op, zoom, x, y, tile id
//   result    done high for one cycle        htid_pkg::rsp_t: id, zoom, x, y, out of range
//
// encode: walks the hilbert levels from transfer to done, one level a cycle.
// decode: zoom search one level a cycle, one subtract, one walk level a
//   cycle; out of range ids finish once the search passes ZOOM_LIMIT.
// both walks share the level unit; decode adds the 64-bit compare/subtract.
// synchronous reset returns to idle; the receiver cannot stall done.
`default_nettype none

module hilbert_tile_id_convert #(
  parameter int ZOOM_LIMIT = htid_pkg::ZOOM_LIMIT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire htid_pkg::req_t  req,
  output logic                 busy,
  output logic                 done,
  output htid_pkg::rsp_t       rsp
);
  import htid_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_SUB    = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]  state;
  logic        dir;
  logic        oor;
  logic [5:0]  zz;
  logic [4:0]  zm;
  logic [4:0]  left;
  logic [63:0] acc;
  logic [30:0] x;
  logic [30:0] y;

  logic [4:0]  lvl;
  logic [30:0] x_next;
  logic [30:0] y_next;
  logic [1:0]  quad;
  logic [63:0] band_end;
  logic [63:0] band_start;
  rsp_t        rsp_next;

  assign busy = (state != ST_IDLE);

  // level index: encode walks down from the top, decode walks up
  assign lvl = (dir == OP_ENCODE) ? (left - 5'd1) : (zm - left);

  assign band_end   = tiles_below(zz + 6'd1);
  assign band_start = tiles_below({1'b0, zm});

  htid_level u_level (
    .dir      (dir),
    .lvl      (lvl),
    .x_in     (x),
    .y_in     (y),
    .quad_in  (acc[1:0]),
    .x_out    (x_next),
    .y_out    (y_next),
    .quad_out (quad)
  );

  // result fields for the finishing cycle
  always_comb begin
    rsp_next = '0;
    if (oor) begin
      rsp_next.out_of_range = 1'b1;
    end else if (dir == OP_ENCODE) begin
      rsp_next.result_id = acc[62:0] + band_start[62:0];
    end else begin
      rsp_next.result_zoom = zm;
      rsp_next.result_x    = x;
      rsp_next.result_y    = y;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_FINISH);
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (req.operation == OP_ENCODE) begin
              if (6'(req.zoom) > 6'(ZOOM_LIMIT)) begin
                state <= ST_FINISH;
              end else begin
                state <= ST_WALK;
              end
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (zz > 6'(ZOOM_LIMIT)) begin
            state <= ST_FINISH;
          end else if (acc < band_end) begin
            state <= ST_SUB;
          end
        end
        ST_SUB: begin
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (left == 5'd0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          dir  <= req.operation;
          zz   <= '0;
          zm   <= req.zoom;
          left <= req.zoom;
          x    <= req.x_coord;
          y    <= req.y_coord;
          if (req.operation == OP_ENCODE) begin
            acc <= '0;
            oor <= (6'(req.zoom) > 6'(ZOOM_LIMIT));
          end else begin
            acc <= req.tile_id;
            oor <= 1'b0;
          end
        end
      end
      ST_SEARCH: begin
        if (zz > 6'(ZOOM_LIMIT)) begin
          oor <= 1'b1;
        end else if (acc < band_end) begin
          zm <= zz[4:0];
        end else begin
          zz <= zz + 6'd1;
        end
      end
      ST_SUB: begin
        acc  <= acc - band_start;
        left <= zm;
        x    <= '0;
        y    <= '0;
      end
      ST_WALK: begin
        if (left != 5'd0) begin
          x    <= x_next;
          y    <= y_next;
          left <= left - 5'd1;
          if (dir == OP_ENCODE) begin
            acc <= {acc[61:0], quad};
          end else begin
            acc <= {2'b00, acc[63:2]};
          end
        end
      end
      ST_FINISH: begin
        rsp <= rsp_next;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/htid_check.sv
// port-level checks for the hilbert tile id converter, bound to the top level
`default_nettype none

module htid_check (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire htid_pkg::rsp_t rsp
);
  import htid_pkg::*;

  // a transfer always starts a conversion
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  // a result shows while the block is already free
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // every finished conversion delivers a result
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("conversion ended without result");

  // out of range results carry zero fields
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.out_of_range) |->
      (rsp.result_id == '0 && rsp.result_zoom == '0 &&
       rsp.result_x == '0 && rsp.result_y == '0))
    else $error("out of range result with nonzero fields");

endmodule

bind hilbert_tile_id_convert htid_check u_htid_check (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire
